/* design/counting_multiset_table_defines.svh */
// ----------------------------------------------------------------------------
// Counting multiset table: assertion macros
// Shared concurrent assertion forms, clocked on the rising edge, reset-gated.
// ----------------------------------------------------------------------------
`ifndef COUNTING_MULTISET_TABLE_DEFINES_SVH
`define COUNTING_MULTISET_TABLE_DEFINES_SVH

// Same-cycle implication.
`define CMT_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("cmt: same-cycle check failed");

// Next-cycle implication.
`define CMT_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("cmt: next-cycle check failed");

`endif

/* design/cmt_pkg.sv */
// ----------------------------------------------------------------------------
// Counting multiset table package
// Sizes, link encoding, field codes and controller/datapath types.
// ----------------------------------------------------------------------------
package cmt_pkg;

    localparam int CAPACITY   = 64;
    localparam int COUNT_BITS = 16;

    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int LINK_W   = $clog2(CAPACITY + 1);     // also holds the null link
    localparam int TOTAL_W  = ADDR_W + COUNT_BITS;      // CAPACITY * max count fits

    localparam int MODE_W   = 2;
    localparam int KEY_W    = 32;
    localparam int STATUS_W = 2;
    localparam int KCNT_W   = 16;
    localparam int BTOT_W   = 22;

    localparam logic [LINK_W-1:0]     NULL_LINK = LINK_W'(CAPACITY);
    localparam logic [LINK_W-1:0]     LAST_STEP = LINK_W'(CAPACITY - 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // mode codes
    localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_AT_MAX    = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WALK,
        S_DECIDE,
        S_ALLOC_RD,
        S_ALLOC_WR,
        S_ALLOC_FIN,
        S_UNLINK,
        S_FREE,
        S_DONE
    } cmt_state_t;

    typedef struct packed {
        logic start;        // capture item, read list head
        logic set_found;    // walk matched the key
        logic walk_next;    // read the following list entry
        logic decide;       // apply count update, latch result
        logic alloc_rd;     // read free-list head
        logic alloc_wr;     // link new entry at list head
        logic alloc_fin;    // clear back link of new head
        logic unlink;       // splice emptied entry out of the list
        logic free_slot;    // push emptied entry on the free list
        logic load_out;     // move result into output register
    } cmt_cmd_t;

    typedef struct packed {
        logic head_null;
        logic hit;
        logic next_null;
        logic need_alloc;
        logic need_release;
        logic out_free;
    } cmt_stat_t;

endpackage

/* design/cmt_ifs.sv */
// ----------------------------------------------------------------------------
// Counting multiset table channels
// Request and response valid/ready channels with their payload.
// ----------------------------------------------------------------------------
interface cmt_req_if import cmt_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [MODE_W-1:0]        mode;
    logic signed [KEY_W-1:0]  key;

    modport source (output valid, mode, key, input ready);
    modport sink   (input valid, mode, key, output ready);
endinterface

interface cmt_rsp_if import cmt_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic                 found;
    logic [KCNT_W-1:0]    key_count;
    logic [BTOT_W-1:0]    bag_total;
    logic                 bag_empty;

    modport source (output valid, status, found, key_count, bag_total, bag_empty,
                    input ready);
    modport sink   (input valid, status, found, key_count, bag_total, bag_empty,
                    output ready);
endinterface

/* design/counting_multiset_table.sv */
// ----------------------------------------------------------------------------
// Counting multiset table
// Multiset of 32-bit keys with per-key occurrence counts, linked-list table.
// ----------------------------------------------------------------------------
// Each request beat carries a mode (0 add, 1 remove, 2 look up; 3 acts as a
// look up) and a key; each yields exactly one response beat with status (0 ok,
// 1 not found, 2 table full, 3 count at maximum), found, the key's count after
// the operation, the bag total and an empty flag. Distinct keys occupy up to
// CAPACITY entries chained newest-first in a doubly linked list; freed
// entries go on a free list. Items are handled one at a time: the request is
// accepted, the search visits list entries in turn (a single registered read
// port feeds the key compare and the next address), the count is updated, a
// new key is then linked in or a key whose count drops to zero is unlinked
// and freed, and the response register is loaded once the previous response
// has been taken.
// The response register lets a new request be accepted while the previous
// response is still waiting. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module counting_multiset_table import cmt_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    cmt_req_if.sink   req,
    cmt_rsp_if.source rsp
);

    cmt_cmd_t  cmd;   // controller -> datapath
    cmt_stat_t st;    // datapath -> controller

    // sequencing: accept, walk, decide, link edits, hand-off
    cmt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .st       (st),
        .cmd      (cmd)
    );

    // entry memories, list and free heads, total, response register
    cmt_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .mode      (req.mode),
        .key       (req.key),
        .cmd       (cmd),
        .st        (st),
        .out_ready (rsp.ready),
        .out_valid (rsp.valid),
        .status    (rsp.status),
        .found     (rsp.found),
        .key_count (rsp.key_count),
        .bag_total (rsp.bag_total),
        .bag_empty (rsp.bag_empty)
    );

endmodule

/* design/cmt_ctrl.sv */
// ----------------------------------------------------------------------------
// Counting multiset table controller
// Sequences accept, list walk, count update, link edits and result hand-off.
// ----------------------------------------------------------------------------
`include "counting_multiset_table_defines.svh"

module cmt_ctrl import cmt_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  cmt_stat_t st,
    output cmt_cmd_t  cmd
);

    cmt_state_t        state_reg, state_next;
    logic [LINK_W-1:0] step_reg, step_next;
    logic              in_fire;

    assign in_fire = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    step_next  = '0;
                    state_next = st.head_null ? S_DECIDE : S_WALK;
                end
            end
            S_WALK:
            begin
                priority if (st.hit)
                begin
                    cmd.set_found = 1'b1;
                    state_next    = S_DECIDE;
                end
                else if (st.next_null || step_reg == LAST_STEP)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    cmd.walk_next = 1'b1;
                    step_next     = step_reg + LINK_W'(1);
                end
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                priority if (st.need_alloc)
                    state_next = S_ALLOC_RD;
                else if (st.need_release)
                    state_next = S_UNLINK;
                else
                    state_next = S_DONE;
            end
            S_ALLOC_RD:
            begin
                cmd.alloc_rd = 1'b1;
                state_next   = S_ALLOC_WR;
            end
            S_ALLOC_WR:
            begin
                cmd.alloc_wr = 1'b1;
                state_next   = S_ALLOC_FIN;
            end
            S_ALLOC_FIN:
            begin
                cmd.alloc_fin = 1'b1;
                state_next    = S_DONE;
            end
            S_UNLINK:
            begin
                cmd.unlink = 1'b1;
                state_next = S_FREE;
            end
            S_FREE:
            begin
                cmd.free_slot = 1'b1;
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                if (st.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `CMT_ASSERT_IMPL(a_walk_bounded, clk, rst_n, state_reg == S_WALK, step_reg < LINK_W'(CAPACITY))
    `CMT_ASSERT_NEXT(a_done_holds, clk, rst_n, (state_reg == S_DONE) && !st.out_free, state_reg == S_DONE)
    `CMT_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_fire, !in_ready)

endmodule

/* design/cmt_datapath.sv */
// ----------------------------------------------------------------------------
// Counting multiset table datapath
// Entry memories, list/free heads, bag total and the result register.
// ----------------------------------------------------------------------------
`include "counting_multiset_table_defines.svh"

module cmt_datapath import cmt_pkg::*; (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [MODE_W-1:0]       mode,
    input  logic signed [KEY_W-1:0] key,
    input  cmt_cmd_t                cmd,
    output cmt_stat_t               st,
    input  logic                    out_ready,
    output logic                    out_valid,
    output logic [STATUS_W-1:0]     status,
    output logic                    found,
    output logic [KCNT_W-1:0]       key_count,
    output logic [BTOT_W-1:0]       bag_total,
    output logic                    bag_empty
);

    // entry memories
    logic [KEY_W-1:0]      key_mem  [CAPACITY];
    logic [COUNT_BITS-1:0] cnt_mem  [CAPACITY];
    logic [LINK_W-1:0]     next_mem [CAPACITY];
    logic [LINK_W-1:0]     prev_mem [CAPACITY];
    logic [CAPACITY-1:0]   next_vld_reg;   // unwritten next link reads as index + 1

    // registered read port
    logic [KEY_W-1:0]      key_rd_reg;
    logic [COUNT_BITS-1:0] cnt_rd_reg;
    logic [LINK_W-1:0]     next_rd_reg;
    logic [LINK_W-1:0]     prev_rd_reg;
    logic                  nvld_rd_reg;
    logic [ADDR_W-1:0]     raddr_reg;
    logic [LINK_W-1:0]     next_val;

    // item and control state
    logic [MODE_W-1:0]     mode_reg;
    logic [KEY_W-1:0]      key_reg;
    logic [LINK_W-1:0]     cur_reg;
    logic                  found_reg;
    logic [LINK_W-1:0]     head_reg, head_next;
    logic [LINK_W-1:0]     free_reg, free_next;
    logic [TOTAL_W-1:0]    total_reg, total_next;
    logic [STATUS_W-1:0]   res_status_reg;
    logic [COUNT_BITS-1:0] res_cnt_reg;

    // result register
    logic                  out_valid_reg;
    logic [STATUS_W-1:0]   out_status_reg;
    logic                  out_found_reg;
    logic [KCNT_W-1:0]     out_cnt_reg;
    logic [BTOT_W-1:0]     out_total_reg;
    logic                  out_empty_reg;

    logic                  rd_en;
    logic [ADDR_W-1:0]     rd_addr;

    logic                  is_add, is_rem;
    logic [STATUS_W-1:0]   dec_status;
    logic [COUNT_BITS-1:0] dec_cnt;
    logic                  dec_cnt_we, dec_inc, dec_dec;

    logic                  key_we;
    logic                  cnt_we;
    logic [ADDR_W-1:0]     cnt_waddr;
    logic [COUNT_BITS-1:0] cnt_wdata;
    logic                  next_we;
    logic [ADDR_W-1:0]     next_waddr;
    logic [LINK_W-1:0]     next_wdata;
    logic                  prev_we;
    logic [ADDR_W-1:0]     prev_waddr;
    logic [LINK_W-1:0]     prev_wdata;

    assign next_val = nvld_rd_reg ? next_rd_reg : LINK_W'(raddr_reg) + LINK_W'(1);

    // read address: list head on start, successor while walking, free head on alloc
    always_comb
    begin
        priority if (cmd.start)
        begin
            rd_en   = 1'b1;
            rd_addr = head_reg[ADDR_W-1:0];
        end
        else if (cmd.walk_next)
        begin
            rd_en   = 1'b1;
            rd_addr = next_val[ADDR_W-1:0];
        end
        else if (cmd.alloc_rd)
        begin
            rd_en   = 1'b1;
            rd_addr = free_reg[ADDR_W-1:0];
        end
        else
        begin
            rd_en   = 1'b0;
            rd_addr = head_reg[ADDR_W-1:0];
        end
    end

    assign is_add = (mode_reg == MODE_ADD);
    assign is_rem = (mode_reg == MODE_REMOVE);

    // count update and result for the decided item
    always_comb
    begin
        dec_status = ST_OK;
        dec_cnt    = '0;
        dec_cnt_we = 1'b0;
        dec_inc    = 1'b0;
        dec_dec    = 1'b0;
        priority if (is_add)
        begin
            priority if (found_reg)
            begin
                if (cnt_rd_reg == COUNT_MAX)
                begin
                    dec_status = ST_AT_MAX;
                    dec_cnt    = cnt_rd_reg;
                end
                else
                begin
                    dec_cnt    = cnt_rd_reg + COUNT_BITS'(1);
                    dec_cnt_we = 1'b1;
                    dec_inc    = 1'b1;
                end
            end
            else if (free_reg == NULL_LINK)
                dec_status = ST_FULL;
            else
                dec_cnt = COUNT_BITS'(1);
        end
        else if (is_rem)
        begin
            if (!found_reg)
                dec_status = ST_NOT_FOUND;
            else
            begin
                dec_cnt    = cnt_rd_reg - COUNT_BITS'(1);
                dec_cnt_we = 1'b1;
                dec_dec    = (total_reg != '0);
            end
        end
        else
        begin
            // lookup, and the unused mode code
            if (!found_reg)
                dec_status = ST_NOT_FOUND;
            else
                dec_cnt = cnt_rd_reg;
        end
    end

    assign st.head_null    = (head_reg == NULL_LINK);
    assign st.hit          = (key_rd_reg == key_reg);
    assign st.next_null    = (next_val == NULL_LINK);
    assign st.need_alloc   = is_add && !found_reg && (free_reg != NULL_LINK);
    assign st.need_release = is_rem && found_reg && (cnt_rd_reg == COUNT_BITS'(1));
    assign st.out_free     = !out_valid_reg || out_ready;

    // write ports
    assign key_we    = cmd.alloc_wr;
    assign cnt_we    = (cmd.decide && dec_cnt_we) || cmd.alloc_wr;
    assign cnt_waddr = cmd.alloc_wr ? free_reg[ADDR_W-1:0] : cur_reg[ADDR_W-1:0];
    assign cnt_wdata = cmd.alloc_wr ? COUNT_BITS'(1) : dec_cnt;

    always_comb
    begin
        priority if (cmd.alloc_wr)
        begin
            next_we    = 1'b1;
            next_waddr = free_reg[ADDR_W-1:0];
            next_wdata = head_reg;
        end
        else if (cmd.unlink)
        begin
            next_we    = (prev_rd_reg != NULL_LINK);
            next_waddr = prev_rd_reg[ADDR_W-1:0];
            next_wdata = next_val;
        end
        else if (cmd.free_slot)
        begin
            next_we    = 1'b1;
            next_waddr = cur_reg[ADDR_W-1:0];
            next_wdata = free_reg;
        end
        else
        begin
            next_we    = 1'b0;
            next_waddr = cur_reg[ADDR_W-1:0];
            next_wdata = free_reg;
        end
    end

    always_comb
    begin
        priority if (cmd.alloc_wr)
        begin
            prev_we    = (head_reg != NULL_LINK);
            prev_waddr = head_reg[ADDR_W-1:0];
            prev_wdata = free_reg;
        end
        else if (cmd.alloc_fin)
        begin
            // head already points at the new entry
            prev_we    = 1'b1;
            prev_waddr = head_reg[ADDR_W-1:0];
            prev_wdata = NULL_LINK;
        end
        else if (cmd.unlink)
        begin
            prev_we    = (next_val != NULL_LINK);
            prev_waddr = next_val[ADDR_W-1:0];
            prev_wdata = prev_rd_reg;
        end
        else
        begin
            prev_we    = 1'b0;
            prev_waddr = head_reg[ADDR_W-1:0];
            prev_wdata = NULL_LINK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
            key_mem[free_reg[ADDR_W-1:0]] <= key_reg;
        if (cnt_we)
            cnt_mem[cnt_waddr] <= cnt_wdata;
        if (next_we)
            next_mem[next_waddr] <= next_wdata;
        if (prev_we)
            prev_mem[prev_waddr] <= prev_wdata;
        if (rd_en)
        begin
            key_rd_reg  <= key_mem[rd_addr];
            cnt_rd_reg  <= cnt_mem[rd_addr];
            next_rd_reg <= next_mem[rd_addr];
            prev_rd_reg <= prev_mem[rd_addr];
            nvld_rd_reg <= next_vld_reg[rd_addr];
            raddr_reg   <= rd_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            next_vld_reg <= '0;
        else if (next_we)
            next_vld_reg[next_waddr] <= 1'b1;
    end

    // heads and total
    always_comb
    begin
        head_next  = head_reg;
        free_next  = free_reg;
        total_next = total_reg;
        if (cmd.decide && dec_inc)
            total_next = total_reg + TOTAL_W'(1);
        if (cmd.decide && dec_dec)
            total_next = total_reg - TOTAL_W'(1);
        if (cmd.alloc_wr)
        begin
            head_next  = free_reg;
            free_next  = next_val;
            total_next = total_reg + TOTAL_W'(1);
        end
        if (cmd.unlink && (prev_rd_reg == NULL_LINK))
            head_next = next_val;
        if (cmd.free_slot)
            free_next = cur_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= NULL_LINK;
            free_reg      <= '0;
            total_reg     <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            free_reg  <= free_next;
            total_reg <= total_next;
            if (cmd.start)
                found_reg <= 1'b0;
            else if (cmd.set_found)
                found_reg <= 1'b1;
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            mode_reg <= mode;
            key_reg  <= key;
            cur_reg  <= head_reg;
        end
        else if (cmd.walk_next)
            cur_reg <= next_val;
        if (cmd.decide)
        begin
            res_status_reg <= dec_status;
            res_cnt_reg    <= dec_cnt;
        end
        if (cmd.load_out)
        begin
            out_status_reg <= res_status_reg;
            out_found_reg  <= found_reg;
            out_cnt_reg    <= KCNT_W'(res_cnt_reg);
            out_total_reg  <= BTOT_W'(total_reg);
            out_empty_reg  <= (total_reg == '0);
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign found     = out_found_reg;
    assign key_count = out_cnt_reg;
    assign bag_total = out_total_reg;
    assign bag_empty = out_empty_reg;

    `CMT_ASSERT_IMPL(a_total_matches_list, clk, rst_n, cmd.start, (total_reg == '0) == (head_reg == NULL_LINK))
    `CMT_ASSERT_IMPL(a_heads_not_both_null, clk, rst_n, head_reg == NULL_LINK, free_reg != NULL_LINK)
    `CMT_ASSERT_NEXT(a_add_bumps_total, clk, rst_n, cmd.decide && dec_inc, total_reg == TOTAL_W'($past(total_reg) + TOTAL_W'(1)))

endmodule

/* dv/counting_multiset_table_test.sv */
// ----------------------------------------------------------------------------
// Counting multiset table testbench
// Table-driven directed beats, then random add/remove/lookup traffic under
// several idle and stall mixes; each response is checked against a predictor or a typed row's value.
// ----------------------------------------------------------------------------
module counting_multiset_table_test;
    import cmt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Mode codes the package does not name. The unused code acts as a lookup.
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SPARE  = 2'd3;

    localparam logic [KEY_W-1:0] KEY_MIN   = 32'h8000_0000;
    localparam logic [KEY_W-1:0] KEY_MAX   = 32'h7FFF_FFFF;
    localparam logic [KEY_W-1:0] KEY_ZERO  = 32'h0000_0000;
    localparam logic [KEY_W-1:0] FILL_BASE = 32'h0000_1000;
    localparam logic [KEY_W-1:0] FILL_NEXT = 32'h0000_1001;

    localparam int RANDOM_PER_PHASE = 175;
    localparam int NUM_PHASES       = 4;

    // Slowest legal run: ~850 beats, each walking up to 64 entries, with random
    // gaps and stalls on top; the limit is set well above it.
    localparam int unsigned LIMIT_CYCLES = 1_000_000;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                found;
        logic [KCNT_W-1:0]   key_count;
        logic [BTOT_W-1:0]   bag_total;
        logic                bag_empty;
    } bag_result_t;

    // One row of directed stimulus. A row repeats reps times, the key stepping
    // by key_step each time. Rows with typed set carry their expected result.
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [KEY_W-1:0]  key;
        int unsigned       reps;
        int unsigned       key_step;
        bit                typed;
        bag_result_t       want;
    } stim_row_t;

    localparam stim_row_t DIRECTED [24] = '{
        // empty bag: every miss reports not found and an empty bag
        '{MODE_LOOKUP, KEY_MIN,  1, 0, 1'b1, '{ST_NOT_FOUND, 1'b0, 16'd0, 22'd0, 1'b1}},
        '{MODE_REMOVE, KEY_MIN,  1, 0, 1'b1, '{ST_NOT_FOUND, 1'b0, 16'd0, 22'd0, 1'b1}},
        '{MODE_SPARE,  KEY_MAX,  1, 0, 1'b1, '{ST_NOT_FOUND, 1'b0, 16'd0, 22'd0, 1'b1}},
        // a few keys in and out; last remove empties the bag again
        '{MODE_ADD,    KEY_MIN,  1, 0, 1'b1, '{ST_OK,        1'b0, 16'd1, 22'd1, 1'b0}},
        '{MODE_ADD,    KEY_MAX,  1, 0, 1'b1, '{ST_OK,        1'b0, 16'd1, 22'd2, 1'b0}},
        '{MODE_ADD,    KEY_MIN,  1, 0, 1'b1, '{ST_OK,        1'b1, 16'd2, 22'd3, 1'b0}},
        '{MODE_LOOKUP, KEY_MIN,  1, 0, 1'b1, '{ST_OK,        1'b1, 16'd2, 22'd3, 1'b0}},
        '{MODE_SPARE,  KEY_MAX,  1, 0, 1'b1, '{ST_OK,        1'b1, 16'd1, 22'd3, 1'b0}},
        '{MODE_REMOVE, KEY_MAX,  1, 0, 1'b1, '{ST_OK,        1'b1, 16'd0, 22'd2, 1'b0}},
        '{MODE_LOOKUP, KEY_MAX,  1, 0, 1'b1, '{ST_NOT_FOUND, 1'b0, 16'd0, 22'd2, 1'b0}},
        '{MODE_ADD,    KEY_ZERO, 1, 0, 1'b1, '{ST_OK,        1'b0, 16'd1, 22'd3, 1'b0}},
        '{MODE_REMOVE, KEY_MIN,  1, 0, 1'b1, '{ST_OK,        1'b1, 16'd1, 22'd2, 1'b0}},
        '{MODE_REMOVE, KEY_MIN,  1, 0, 1'b1, '{ST_OK,        1'b1, 16'd0, 22'd1, 1'b0}},
        '{MODE_REMOVE, KEY_ZERO, 1, 0, 1'b1, '{ST_OK,        1'b1, 16'd0, 22'd0, 1'b1}},
        // fill every entry, hit the full table, walk to the tail
        '{MODE_ADD,    FILL_BASE, 64, 1, 1'b0, '0},
        '{MODE_ADD,    KEY_MAX,  1, 0, 1'b1, '{ST_FULL, 1'b0, 16'd0, 22'd64, 1'b0}},
        '{MODE_LOOKUP, FILL_BASE, 1, 0, 1'b1, '{ST_OK,  1'b1, 16'd1, 22'd64, 1'b0}},
        '{MODE_ADD,    FILL_BASE, 1, 0, 1'b1, '{ST_OK,  1'b1, 16'd2, 22'd65, 1'b0}},
        // drain the other fill keys and reuse a freed entry
        '{MODE_REMOVE, FILL_NEXT, 63, 1, 1'b0, '0},
        '{MODE_ADD,    KEY_MAX,  1, 0, 1'b1, '{ST_OK,   1'b0, 16'd1, 22'd3, 1'b0}},
        '{MODE_LOOKUP, FILL_NEXT, 1, 0, 1'b1, '{ST_NOT_FOUND, 1'b0, 16'd0, 22'd3, 1'b0}},
        '{MODE_REMOVE, FILL_BASE, 1, 0, 1'b1, '{ST_OK,  1'b1, 16'd1, 22'd2, 1'b0}},
        '{MODE_REMOVE, FILL_BASE, 1, 0, 1'b1, '{ST_OK,  1'b1, 16'd0, 22'd1, 1'b0}},
        '{MODE_REMOVE, KEY_MAX,  1, 0, 1'b1, '{ST_OK,   1'b1, 16'd0, 22'd0, 1'b1}}
    };

    // Idle mixes per random phase: none, sender only, receiver only, both.
    localparam int SEND_IDLE_MIX [NUM_PHASES] = '{0, 49, 0, 23};
    localparam int STALL_MIX     [NUM_PHASES] = '{0, 0, 49, 23};

    logic clk = 1'b0;
    logic rst_n;

    cmt_req_if req_ch ();
    cmt_rsp_if rsp_ch ();

    counting_multiset_table dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    int          send_idle_pct = 0;
    int          stall_pct     = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;

    bag_result_t pending_results [$];

    // ------------------------------------------------------------------------
    // Predictor state: the table, its two chains and the running total.
    // ------------------------------------------------------------------------
    logic [KEY_W-1:0]      slot_key   [CAPACITY];
    logic [COUNT_BITS-1:0] slot_count [CAPACITY];
    logic [LINK_W-1:0]     slot_next  [CAPACITY];
    logic [LINK_W-1:0]     slot_prev  [CAPACITY];
    logic [LINK_W-1:0]     chain_head;
    logic [LINK_W-1:0]     spare_head;
    int unsigned           occ_total;

    // Applies one beat to the predicted table and returns its response.
    function automatic bag_result_t apply_bag_op(input logic [MODE_W-1:0] op,
                                                 input logic [KEY_W-1:0]  k);
        logic [LINK_W-1:0]     hit;
        logic [LINK_W-1:0]     cur;
        logic [LINK_W-1:0]     s;
        logic [LINK_W-1:0]     p;
        logic [LINK_W-1:0]     n;
        logic                  present;
        logic [COUNT_BITS-1:0] cnt;
        bag_result_t           res;

        // search newest-first, never more than CAPACITY hops
        hit = NULL_LINK;
        cur = chain_head;
        for (int steps = 0; steps < CAPACITY && cur < NULL_LINK; steps++)
        begin
            if (slot_key[cur] == k)
            begin
                hit = cur;
                break;
            end
            cur = slot_next[cur];
        end

        present    = (hit < NULL_LINK);
        cnt        = present ? slot_count[hit] : '0;
        res.status = ST_OK;

        case (op)
            MODE_ADD:
            begin
                if (present)
                begin
                    if (cnt == COUNT_MAX)
                        res.status = ST_AT_MAX;
                    else
                    begin
                        cnt             = cnt + 1'b1;
                        slot_count[hit] = cnt;
                        occ_total++;
                    end
                end
                else if (spare_head >= NULL_LINK)
                    res.status = ST_FULL;
                else
                begin
                    // pop the free chain, push on the list head
                    s             = spare_head;
                    spare_head    = slot_next[s];
                    slot_key[s]   = k;
                    slot_count[s] = COUNT_BITS'(1);
                    slot_next[s]  = chain_head;
                    slot_prev[s]  = NULL_LINK;
                    if (chain_head < NULL_LINK)
                        slot_prev[chain_head] = s;
                    chain_head = s;
                    cnt        = COUNT_BITS'(1);
                    occ_total++;
                end
            end
            MODE_REMOVE:
            begin
                if (!present)
                    res.status = ST_NOT_FOUND;
                else
                begin
                    cnt             = cnt - 1'b1;
                    slot_count[hit] = cnt;
                    if (occ_total > 0)
                        occ_total--;
                    if (cnt == 0)
                    begin
                        // splice out, then push on the free chain
                        p = slot_prev[hit];
                        n = slot_next[hit];
                        if (p < NULL_LINK)
                            slot_next[p] = n;
                        else
                            chain_head = n;
                        if (n < NULL_LINK)
                            slot_prev[n] = p;
                        slot_next[hit] = spare_head;
                        slot_prev[hit] = NULL_LINK;
                        spare_head     = hit;
                    end
                end
            end
            default:
            begin
                if (!present)
                    res.status = ST_NOT_FOUND;
            end
        endcase

        res.found     = present;
        res.key_count = KCNT_W'(cnt);
        res.bag_total = BTOT_W'(occ_total);
        res.bag_empty = (occ_total == 0);
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    // Drives one request beat and records its expected response once it is
    // accepted. A random gap may come first; valid stays high otherwise, so
    // back-to-back beats never drop it within a step.
    task automatic send_item(input logic [MODE_W-1:0] op, input logic [KEY_W-1:0] k,
                             input bit typed, input bag_result_t typed_want);
        bag_result_t model_want;

        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.mode  <= op;
        req_ch.key   <= k;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);

        // predictor always advances; typed rows pin the expected value
        model_want = apply_bag_op(op, k);
        pending_results.push_back(typed ? typed_want : model_want);
    endtask

    // Receiver: ready toggles at random per the current stall mix.
    always @(posedge clk)
        rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);

    // Response checker: values are read as they stood before the edge.
    always @(posedge clk)
    begin
        bag_result_t want;
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (pending_results.size() == 0)
                report_mismatch("response beat with nothing outstanding");
            else
            begin
                want = pending_results.pop_front();
                check_field("status",    32'(rsp_ch.status),    32'(want.status));
                check_field("found",     32'(rsp_ch.found),     32'(want.found));
                check_field("key_count", 32'(rsp_ch.key_count), 32'(want.key_count));
                check_field("bag_total", 32'(rsp_ch.bag_total), 32'(want.bag_total));
                check_field("bag_empty", 32'(rsp_ch.bag_empty), 32'(want.bag_empty));
            end
        end
    end

    // Watchdog.
    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[%0t] timeout, %0d responses outstanding", $realtime,
                 pending_results.size());
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        logic [KEY_W-1:0]  key_pool [$];
        logic [MODE_W-1:0] op;
        logic [KEY_W-1:0]  k;
        int unsigned       roll;
        int                pool_size;

        req_ch.valid = 1'b0;
        req_ch.mode  = MODE_ADD;
        req_ch.key   = '0;
        rst_n        = 1'b0;

        // predictor reset: free chain runs 0..CAPACITY-1, list empty
        for (int i = 0; i < CAPACITY; i++)
        begin
            slot_key[i]   = '0;
            slot_count[i] = '0;
            slot_next[i]  = (i + 1 < CAPACITY) ? LINK_W'(i + 1) : NULL_LINK;
            slot_prev[i]  = NULL_LINK;
        end
        chain_head = NULL_LINK;
        spare_head = '0;
        occ_total  = 0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed table, no idling
        foreach (DIRECTED[i])
            for (int n = 0; n < DIRECTED[i].reps; n++)
                send_item(DIRECTED[i].mode,
                          DIRECTED[i].key + KEY_W'(n * DIRECTED[i].key_step),
                          DIRECTED[i].typed, DIRECTED[i].want);

        // Random phases. Keys come mostly from a per-phase pool so adds,
        // hits and removes to zero keep meeting; pool size varies so a phase can
        // run the table into full. A few keys are fully random.
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            send_idle_pct = SEND_IDLE_MIX[ph];
            stall_pct     = STALL_MIX[ph];
            pool_size     = $urandom_range(6, 90);
            key_pool.delete();
            repeat (pool_size)
                key_pool.push_back($urandom);

            repeat (RANDOM_PER_PHASE)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 48)
                    op = MODE_ADD;
                else if (roll < 78)
                    op = MODE_REMOVE;
                else if (roll < 95)
                    op = MODE_LOOKUP;
                else
                    op = MODE_SPARE;
                if ($urandom_range(0, 15) == 0)
                    k = $urandom;
                else
                    k = key_pool[$urandom_range(0, pool_size - 1)];
                send_item(op, k, 1'b0, '0);
            end
        end
        req_ch.valid <= 1'b0;

        // drain, then a quiet stretch to catch stray beats
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (CAPACITY + 8) @(posedge clk);

        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* sim.f */
+incdir+design
design/cmt_pkg.sv
design/cmt_ifs.sv
design/cmt_ctrl.sv
design/cmt_datapath.sv
design/counting_multiset_table.sv
dv/counting_multiset_table_test.sv
